// File: sv/tpi_pkg.sv
// shared constants and types for the three-plane intersection block
package tpi_pkg;

    localparam int COEFF_WIDTH_DEF = 24;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int OUT_WIDTH_DEF   = 48;

    localparam int              THR_WIDTH = 63;
    localparam logic [62:0]     THR_RESET = 63'd3;

    // pipeline advance and the valid bit entering a stage group
    typedef struct packed {
        logic en;
        logic valid;
    } t_stage_ctl;

endpackage

// File: sv/tpi_channels.sv
// channel interfaces: plane triples in, intersection points out, threshold writes
interface tpi_plane_if import tpi_pkg::*; #(
    parameter int COEFF_WIDTH = COEFF_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COEFF_WIDTH-1:0] plane0_a;
    logic signed [COEFF_WIDTH-1:0] plane0_b;
    logic signed [COEFF_WIDTH-1:0] plane0_c;
    logic signed [COEFF_WIDTH-1:0] plane0_d;
    logic signed [COEFF_WIDTH-1:0] plane1_a;
    logic signed [COEFF_WIDTH-1:0] plane1_b;
    logic signed [COEFF_WIDTH-1:0] plane1_c;
    logic signed [COEFF_WIDTH-1:0] plane1_d;
    logic signed [COEFF_WIDTH-1:0] plane2_a;
    logic signed [COEFF_WIDTH-1:0] plane2_b;
    logic signed [COEFF_WIDTH-1:0] plane2_c;
    logic signed [COEFF_WIDTH-1:0] plane2_d;

    modport source (
        output valid, plane0_a, plane0_b, plane0_c, plane0_d,
               plane1_a, plane1_b, plane1_c, plane1_d,
               plane2_a, plane2_b, plane2_c, plane2_d,
        input  ready
    );
    modport sink (
        input  valid, plane0_a, plane0_b, plane0_c, plane0_d,
               plane1_a, plane1_b, plane1_c, plane1_d,
               plane2_a, plane2_b, plane2_c, plane2_d,
        output ready
    );
endinterface

interface tpi_point_if import tpi_pkg::*; #(
    parameter int OUT_WIDTH = OUT_WIDTH_DEF
) ();
    logic                        valid;
    logic                        ready;
    logic signed [OUT_WIDTH-1:0] point_x;
    logic signed [OUT_WIDTH-1:0] point_y;
    logic signed [OUT_WIDTH-1:0] point_z;
    logic                        valid_res;
    logic                        saturated;

    modport source (
        output valid, point_x, point_y, point_z, valid_res, saturated,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_z, valid_res, saturated,
        output ready
    );
endinterface

interface tpi_cfg_if import tpi_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [THR_WIDTH-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// File: sv/three_plane_intersection.sv
// top level: three-plane intersection by cramer's rule, fully pipelined
//
// i_planes carries one plane triple per transaction, twelve signed
// fixed-point coefficients. o_point returns one transaction per input:
// the intersection point, valid_res and saturated. the user is to write
// the determinant threshold over i_cfg only while the block is idle; the
// block does not enforce this. i_cfg is always ready. the pipe holds two
// minor stages, three determinant stages, two stages of magnitude and
// overflow checks, one divider stage per output bit and the clamp and
// output registers. a new transaction is taken every cycle while
// i_planes.ready is high; the divider, one quotient bit per stage, sets
// the depth. all stages move on one shared enable. a two-entry output
// buffer lets the pipe keep going for one transaction while the receiver
// stalls; after that i_planes.ready drops until the receiver takes one.
// reset clears every valid bit and sets the threshold to 3.
module three_plane_intersection import tpi_pkg::*; #(
    parameter int COEFF_WIDTH = COEFF_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int OUT_WIDTH   = OUT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tpi_plane_if.sink   i_planes,
    tpi_cfg_if.sink     i_cfg,
    tpi_point_if.source o_point
);

    localparam int EW   = COEFF_WIDTH + 1;
    localparam int MW   = 2 * EW + 1;
    localparam int DW   = 3 * COEFF_WIDTH + 6;
    localparam int NHW  = DW + FRAC_BITS;
    localparam int NXW  = NHW + OUT_WIDTH;
    localparam int CMPW = (DW > THR_WIDTH) ? DW : THR_WIDTH;
    localparam int OW   = OUT_WIDTH;

    // threshold register
    logic [THR_WIDTH-1:0] r_thr;

    // pipeline enable: room in the output buffer
    logic w_en;

    // input coefficients widened by one bit so -d fits
    logic signed [EW-1:0] w_m [3][3];
    logic signed [EW-1:0] w_nd [3];

    logic                 m_valid;
    logic signed [EW-1:0] m_row0 [4][3];
    logic signed [MW-1:0] m_minor [4][3];

    logic                 d_valid;
    logic signed [DW-1:0] d_det [4];

    // stage 6: magnitudes and signs
    logic          r_v6;
    logic [DW-1:0] r_den6;
    logic [DW-1:0] r_num6 [3];
    logic          r_neg6 [3];
    logic [DW-1:0] n_num6 [3];
    logic [DW-1:0] n_den6;
    logic          n_neg6 [3];

    // stage 7: threshold test, numerator alignment, quotient overflow
    logic          r_v7;
    logic [DW-1:0] r_den7;
    logic          r_ok7;
    logic [DW-1:0] r_rem7 [3];
    logic [OW-1:0] r_nlo7 [3];
    logic          r_neg7 [3];
    logic          r_ovf7 [3];
    logic [DW-1:0] n_rem7 [3];
    logic [OW-1:0] n_nlo7 [3];
    logic          n_ovf7 [3];

    logic                 q_valid;
    logic signed [OW-1:0] q_point [3];
    logic                 q_vres;
    logic                 q_sat;

    // output register and skid entry
    logic                 r_ov;
    logic                 r_sv;
    logic signed [OW-1:0] r_o_pt [3];
    logic                 r_o_vres;
    logic                 r_o_sat;
    logic signed [OW-1:0] r_s_pt [3];
    logic                 r_s_vres;
    logic                 r_s_sat;
    logic                 w_push;
    logic                 w_pop;

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg.valid) begin
            r_thr <= i_cfg.data;
        end
    end

    assign w_en           = !r_sv;
    assign i_planes.ready = w_en;

    assign w_m[0][0] = EW'(i_planes.plane0_a);
    assign w_m[0][1] = EW'(i_planes.plane0_b);
    assign w_m[0][2] = EW'(i_planes.plane0_c);
    assign w_m[1][0] = EW'(i_planes.plane1_a);
    assign w_m[1][1] = EW'(i_planes.plane1_b);
    assign w_m[1][2] = EW'(i_planes.plane1_c);
    assign w_m[2][0] = EW'(i_planes.plane2_a);
    assign w_m[2][1] = EW'(i_planes.plane2_b);
    assign w_m[2][2] = EW'(i_planes.plane2_c);
    assign w_nd[0]   = -EW'(i_planes.plane0_d);
    assign w_nd[1]   = -EW'(i_planes.plane1_d);
    assign w_nd[2]   = -EW'(i_planes.plane2_d);

    tpi_minor #(
        .COEFF_WIDTH (COEFF_WIDTH)
    ) u_minor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   ('{en: w_en, valid: i_planes.valid}),
        .i_m     (w_m),
        .i_nd    (w_nd),
        .o_valid (m_valid),
        .o_row0  (m_row0),
        .o_minor (m_minor)
    );

    tpi_det #(
        .COEFF_WIDTH (COEFF_WIDTH)
    ) u_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   ('{en: w_en, valid: m_valid}),
        .i_row0  (m_row0),
        .i_minor (m_minor),
        .o_valid (d_valid),
        .o_det   (d_det)
    );

    // dets 0..2 are the x, y, z numerators, det 3 the denominator
    always_comb begin
        n_den6 = d_det[3][DW-1] ? (~d_det[3] + 1'b1) : d_det[3];
        for (int l = 0; l < 3; l++) begin
            n_num6[l] = d_det[l][DW-1] ? (~d_det[l] + 1'b1) : d_det[l];
            n_neg6[l] = d_det[l][DW-1] ^ d_det[3][DW-1];
        end
    end

    // quotient fits the output width only if the top of the numerator is below the divisor
    always_comb begin
        logic [NXW-1:0] nsh;
        logic [NHW-1:0] nhi;
        for (int l = 0; l < 3; l++) begin
            nsh       = NXW'(r_num6[l]) << FRAC_BITS;
            nhi       = nsh[NXW-1:OW];
            n_ovf7[l] = nhi >= NHW'(r_den6);
            n_rem7[l] = nhi[DW-1:0];
            n_nlo7[l] = nsh[OW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else if (w_en) begin
            r_v6 <= d_valid;
            r_v7 <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_den6 <= n_den6;
            r_num6 <= n_num6;
            r_neg6 <= n_neg6;
            r_den7 <= r_den6;
            // zero determinant is degenerate even with a zero threshold
            r_ok7  <= (r_den6 != '0) && (CMPW'(r_den6) >= CMPW'(r_thr));
            r_rem7 <= n_rem7;
            r_nlo7 <= n_nlo7;
            r_neg7 <= r_neg6;
            r_ovf7 <= n_ovf7;
        end
    end

    tpi_div #(
        .DEN_WIDTH (DW),
        .OUT_WIDTH (OUT_WIDTH)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       ('{en: w_en, valid: r_v7}),
        .i_den       (r_den7),
        .i_rem       (r_rem7),
        .i_nlo       (r_nlo7),
        .i_neg       (r_neg7),
        .i_ovf       (r_ovf7),
        .i_tag       (r_ok7),
        .o_valid     (q_valid),
        .o_point     (q_point),
        .o_valid_res (q_vres),
        .o_saturated (q_sat)
    );

    // output buffer: the last stage leaves the pipe whenever it advances
    assign w_push = w_en && q_valid;
    assign w_pop  = r_ov && o_point.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (w_pop) begin
                r_sv <= 1'b0;
            end
        end else if (w_push) begin
            if (!r_ov || w_pop) begin
                r_ov <= 1'b1;
            end else begin
                r_sv <= 1'b1;
            end
        end else if (w_pop) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (w_pop) begin
                r_o_pt   <= r_s_pt;
                r_o_vres <= r_s_vres;
                r_o_sat  <= r_s_sat;
            end
        end else if (w_push) begin
            if (!r_ov || w_pop) begin
                r_o_pt   <= q_point;
                r_o_vres <= q_vres;
                r_o_sat  <= q_sat;
            end else begin
                r_s_pt   <= q_point;
                r_s_vres <= q_vres;
                r_s_sat  <= q_sat;
            end
        end
    end

    assign o_point.valid     = r_ov;
    assign o_point.point_x   = r_o_pt[0];
    assign o_point.point_y   = r_o_pt[1];
    assign o_point.point_z   = r_o_pt[2];
    assign o_point.valid_res = r_o_vres;
    assign o_point.saturated = r_o_sat;

endmodule

// File: sv/tpi_minor.sv
// stages 1-2: 2x2 minors of rows 1 and 2 for the main and the three replaced-column matrices
module tpi_minor import tpi_pkg::*; #(
    parameter int COEFF_WIDTH = COEFF_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_stage_ctl                   i_ctl,
    input  logic signed [COEFF_WIDTH:0]  i_m [3][3],
    input  logic signed [COEFF_WIDTH:0]  i_nd [3],
    output logic                         o_valid,
    output logic signed [COEFF_WIDTH:0]  o_row0 [4][3],
    output logic signed [2*COEFF_WIDTH+2:0] o_minor [4][3]
);

    localparam int EW = COEFF_WIDTH + 1;
    localparam int PW = 2 * EW;
    localparam int MW = 2 * EW + 1;

    logic signed [EW-1:0] w_mat [4][3][3];
    logic signed [PW-1:0] n_p0 [4][3];
    logic signed [PW-1:0] n_p1 [4][3];

    logic                 r_v1;
    logic                 r_v2;
    logic signed [PW-1:0] r_p0 [4][3];
    logic signed [PW-1:0] r_p1 [4][3];
    logic signed [EW-1:0] r_row0a [4][3];
    logic signed [EW-1:0] r_row0b [4][3];
    logic signed [MW-1:0] r_minor [4][3];

    // matrix k has column k replaced by -d; k = 3 is the plain normal matrix
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    w_mat[k][r][c] = (c == k) ? i_nd[r] : i_m[r][c];
                end
            end
        end
    end

    // cofactor j of row 0, sign folded in for the middle column
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            for (int j = 0; j < 3; j++) begin
                if (j == 0) begin
                    n_p0[k][j] = w_mat[k][1][1] * w_mat[k][2][2];
                    n_p1[k][j] = w_mat[k][1][2] * w_mat[k][2][1];
                end else if (j == 1) begin
                    n_p0[k][j] = w_mat[k][1][2] * w_mat[k][2][0];
                    n_p1[k][j] = w_mat[k][1][0] * w_mat[k][2][2];
                end else begin
                    n_p0[k][j] = w_mat[k][1][0] * w_mat[k][2][1];
                    n_p1[k][j] = w_mat[k][1][1] * w_mat[k][2][0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_ctl.en) begin
            r_v1 <= i_ctl.valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_p0    <= n_p0;
            r_p1    <= n_p1;
            r_row0b <= r_row0a;
            for (int k = 0; k < 4; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_row0a[k][j] <= w_mat[k][0][j];
                    r_minor[k][j] <= MW'(r_p0[k][j]) - MW'(r_p1[k][j]);
                end
            end
        end
    end

    assign o_valid = r_v2;
    assign o_row0  = r_row0b;
    assign o_minor = r_minor;

endmodule

// File: sv/tpi_det.sv
// stages 3-5: row 0 times cofactors in split partial products, then the determinant sums
module tpi_det import tpi_pkg::*; #(
    parameter int COEFF_WIDTH = COEFF_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_stage_ctl                      i_ctl,
    input  logic signed [COEFF_WIDTH:0]     i_row0 [4][3],
    input  logic signed [2*COEFF_WIDTH+2:0] i_minor [4][3],
    output logic                            o_valid,
    output logic signed [3*COEFF_WIDTH+5:0] o_det [4]
);

    localparam int EW   = COEFF_WIDTH + 1;
    localparam int MW   = 2 * EW + 1;
    localparam int L    = EW;
    localparam int HW   = MW - L;
    localparam int LOW  = EW + L + 1;
    localparam int HIW  = EW + HW;
    localparam int PRW  = EW + MW;
    localparam int DW   = EW + MW + 2;

    logic                  r_v3;
    logic                  r_v4;
    logic                  r_v5;
    logic signed [LOW-1:0] r_lo [4][3];
    logic signed [HIW-1:0] r_hi [4][3];
    logic signed [PRW-1:0] r_prod [4][3];
    logic signed [DW-1:0]  r_det [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (i_ctl.en) begin
            r_v3 <= i_ctl.valid;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            for (int k = 0; k < 4; k++) begin
                for (int j = 0; j < 3; j++) begin
                    // low half of the cofactor is unsigned, high half carries the sign
                    r_lo[k][j]   <= i_row0[k][j] * $signed({1'b0, i_minor[k][j][L-1:0]});
                    r_hi[k][j]   <= i_row0[k][j] * $signed(i_minor[k][j][MW-1:L]);
                    r_prod[k][j] <= (PRW'(r_hi[k][j]) <<< L) + PRW'(r_lo[k][j]);
                end
                r_det[k] <= DW'(r_prod[k][0]) + DW'(r_prod[k][1]) + DW'(r_prod[k][2]);
            end
        end
    end

    assign o_valid = r_v5;
    assign o_det   = r_det;

endmodule

// File: sv/tpi_div.sv
// pipelined restoring divider, one quotient bit per stage for three lanes, then clamp
module tpi_div import tpi_pkg::*; #(
    parameter int DEN_WIDTH = 3 * COEFF_WIDTH_DEF + 6,
    parameter int OUT_WIDTH = OUT_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_stage_ctl                  i_ctl,
    input  logic [DEN_WIDTH-1:0]        i_den,
    input  logic [DEN_WIDTH-1:0]        i_rem [3],
    input  logic [OUT_WIDTH-1:0]        i_nlo [3],
    input  logic                        i_neg [3],
    input  logic                        i_ovf [3],
    input  logic                        i_tag,
    output logic                        o_valid,
    output logic signed [OUT_WIDTH-1:0] o_point [3],
    output logic                        o_valid_res,
    output logic                        o_saturated
);

    localparam int DW = DEN_WIDTH;
    localparam int OW = OUT_WIDTH;

    logic          r_v   [OW];
    logic          r_tag [OW];
    logic [DW-1:0] r_den [OW];
    logic [DW-1:0] r_rem [OW][3];
    logic [OW-1:0] r_qn  [OW][3];
    logic          r_neg [OW][3];
    logic          r_ovf [OW][3];

    logic                 r_fv;
    logic signed [OW-1:0] r_pt [3];
    logic                 r_vres;
    logic                 r_sat;

    logic signed [OW-1:0] n_pt [3];
    logic                 n_sat;

    for (genvar j = 0; j < OW; j++) begin : g_step
        logic          p_v;
        logic          p_tag;
        logic [DW-1:0] p_den;
        logic [DW-1:0] p_rem [3];
        logic [OW-1:0] p_qn  [3];
        logic          p_neg [3];
        logic          p_ovf [3];
        logic [DW-1:0] n_rem [3];
        logic [OW-1:0] n_qn  [3];

        if (j == 0) begin : g_first
            assign p_v   = i_ctl.valid;
            assign p_tag = i_tag;
            assign p_den = i_den;
            assign p_rem = i_rem;
            assign p_qn  = i_nlo;
            assign p_neg = i_neg;
            assign p_ovf = i_ovf;
        end else begin : g_next
            assign p_v   = r_v[j-1];
            assign p_tag = r_tag[j-1];
            assign p_den = r_den[j-1];
            assign p_rem = r_rem[j-1];
            assign p_qn  = r_qn[j-1];
            assign p_neg = r_neg[j-1];
            assign p_ovf = r_ovf[j-1];
        end

        // numerator bits shift out of the top while quotient bits enter at the bottom
        always_comb begin
            logic [DW:0] t;
            for (int l = 0; l < 3; l++) begin
                t = {p_rem[l], p_qn[l][OW-1]};
                if (t >= {1'b0, p_den}) begin
                    n_rem[l] = DW'(t - {1'b0, p_den});
                    n_qn[l]  = {p_qn[l][OW-2:0], 1'b1};
                end else begin
                    n_rem[l] = t[DW-1:0];
                    n_qn[l]  = {p_qn[l][OW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_ctl.en) begin
                r_v[j] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_tag[j] <= p_tag;
                r_den[j] <= p_den;
                r_rem[j] <= n_rem;
                r_qn[j]  <= n_qn;
                r_neg[j] <= p_neg;
                r_ovf[j] <= p_ovf;
            end
        end
    end

    // clamp to the signed output range, zero for degenerate planes
    always_comb begin
        logic [OW-1:0] q;
        logic          s;
        n_sat = 1'b0;
        for (int l = 0; l < 3; l++) begin
            q = r_qn[OW-1][l];
            if (!r_neg[OW-1][l]) begin
                s = r_ovf[OW-1][l] | q[OW-1];
                n_pt[l] = s ? $signed({1'b0, {(OW-1){1'b1}}}) : $signed(q);
            end else begin
                s = r_ovf[OW-1][l] | (q[OW-1] & (|q[OW-2:0]));
                n_pt[l] = s ? $signed({1'b1, {(OW-1){1'b0}}}) : $signed(~q + 1'b1);
            end
            if (!r_tag[OW-1]) begin
                n_pt[l] = '0;
                s       = 1'b0;
            end
            n_sat = n_sat | s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (i_ctl.en) begin
            r_fv <= r_v[OW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_pt   <= n_pt;
            r_vres <= r_tag[OW-1];
            r_sat  <= n_sat;
        end
    end

    assign o_valid     = r_fv;
    assign o_point     = r_pt;
    assign o_valid_res = r_vres;
    assign o_saturated = r_sat;

endmodule
